>>> design/olcf_pkg.sv
// ----------------------------------------------------------------------------
// olcf_pkg: shared constants for the mesh text line classifier
// Character codes, line class codes and the line counter width.
// ----------------------------------------------------------------------------
`default_nettype none

package olcf_pkg;

  // Width of each per-class line counter (8 to 32).
  localparam int COUNT_WIDTH = 24;
  // Width of the line_count output field.
  localparam int LINE_COUNT_W = 24;
  localparam int NUM_CLASSES = 4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [1:0] line_class_t;

  localparam line_class_t CLASS_VERTEX   = 2'd0;
  localparam line_class_t CLASS_NORMAL   = 2'd1;
  localparam line_class_t CLASS_TEXCOORD = 2'd2;
  localparam line_class_t CLASS_FACE     = 2'd3;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;

  // True for characters that are passed on inside a classed line.
  function automatic logic passes_filter(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_NL || c == CH_TAB ||
           c == CH_SPACE || c == CH_MINUS || c == CH_DOT;
  endfunction

endpackage

`default_nettype wire

>>> design/obj_line_classifier_filter.sv
// ----------------------------------------------------------------------------
// obj_line_classifier_filter: mesh text line classifier and character filter
// Classes vertex, normal, texcoord and face lines, passes on their numeric
// characters and counts the lines of each class.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, in_byte, end_of_file) takes one
//   character of the file per transaction. The output channel
//   (out_valid/out_ready) carries at most one kept character per input
//   character, or four line counts (vertex, normal, texcoord, face) after an
//   end_of_file transaction; last_result marks the final result of an input.
//   A result appears on the output the cycle after its input transaction.
//   Throughput is one character per cycle while the receiver accepts each
//   result, set by the single result register that the classification logic
//   feeds; an end of file occupies the output for four beats, and no input is
//   taken until the face count beat is accepted.
//   A new input is taken while a result waits, provided that result is the
//   last of its input and is accepted in the same cycle, or is not pending.
//   Reset (rst, synchronous) empties the output register, clears all counts
//   and the line state, and sets the two byte history to newline. End of
//   file clears counts, line state and history the same way. When the
//   receiver stalls, the held result stays put and in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module obj_line_classifier_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       line_class,
  output logic             is_count,
  output logic [7:0]       kept_char,
  output logic [olcf_pkg::LINE_COUNT_W-1:0] line_count,
  output logic             last_result
);

  // Line state.
  logic [7:0]            previous_byte, previous_byte_next;
  logic [7:0]            byte_before_previous, byte_before_previous_next;
  logic                  line_active, line_active_next;
  olcf_pkg::line_class_t active_class, active_class_next;
  olcf_pkg::count_t      class_counts [olcf_pkg::NUM_CLASSES];

  // Result register.
  olcf_pkg::line_class_t out_class;
  logic [7:0]            out_char;
  logic                  cnt_mode;
  logic [1:0]            cnt_idx;
  olcf_pkg::count_t      cnt_snap [olcf_pkg::NUM_CLASSES];

  logic                  in_fire, out_fire, final_beat;
  logic                  tag_hit, active_now, emit, closes_line;
  olcf_pkg::line_class_t tag_class, class_now;
  logic [7:0]            c_mod;

  assign final_beat = !cnt_mode || (cnt_idx == olcf_pkg::CLASS_FACE);
  assign in_ready   = !out_valid || (out_ready && final_beat);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;

  // Classification of one character.
  always_comb begin
    tag_hit   = 1'b0;
    tag_class = olcf_pkg::CLASS_VERTEX;
    if (byte_before_previous == olcf_pkg::CH_NL) begin
      if (previous_byte == olcf_pkg::CH_V) begin
        if (in_byte == olcf_pkg::CH_SPACE) begin
          tag_hit   = 1'b1;
          tag_class = olcf_pkg::CLASS_VERTEX;
        end else if (in_byte == olcf_pkg::CH_N) begin
          tag_hit   = 1'b1;
          tag_class = olcf_pkg::CLASS_NORMAL;
        end else if (in_byte == olcf_pkg::CH_T) begin
          tag_hit   = 1'b1;
          tag_class = olcf_pkg::CLASS_TEXCOORD;
        end
      end else if (previous_byte == olcf_pkg::CH_F && in_byte == olcf_pkg::CH_SPACE) begin
        tag_hit   = 1'b1;
        tag_class = olcf_pkg::CLASS_FACE;
      end
    end

    active_now = tag_hit || line_active;
    class_now  = tag_hit ? tag_class : active_class;

    if (active_now && class_now == olcf_pkg::CLASS_FACE && in_byte == olcf_pkg::CH_SLASH) begin
      c_mod = olcf_pkg::CH_SPACE;
    end else begin
      c_mod = in_byte;
    end

    emit        = active_now && olcf_pkg::passes_filter(c_mod);
    closes_line = active_now && (c_mod == olcf_pkg::CH_NL);

    line_active_next          = active_now && !closes_line;
    active_class_next         = class_now;
    previous_byte_next        = c_mod;
    byte_before_previous_next = previous_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte        <= olcf_pkg::CH_NL;
      byte_before_previous <= olcf_pkg::CH_NL;
      line_active          <= 1'b0;
      active_class         <= olcf_pkg::CLASS_VERTEX;
      for (int i = 0; i < olcf_pkg::NUM_CLASSES; i++) begin
        class_counts[i] <= '0;
      end
    end else if (in_fire) begin
      if (end_of_file) begin
        previous_byte        <= olcf_pkg::CH_NL;
        byte_before_previous <= olcf_pkg::CH_NL;
        line_active          <= 1'b0;
        active_class         <= olcf_pkg::CLASS_VERTEX;
        for (int i = 0; i < olcf_pkg::NUM_CLASSES; i++) begin
          class_counts[i] <= '0;
        end
      end else begin
        previous_byte        <= previous_byte_next;
        byte_before_previous <= byte_before_previous_next;
        line_active          <= line_active_next;
        active_class         <= active_class_next;
        for (int i = 0; i < olcf_pkg::NUM_CLASSES; i++) begin
          if (closes_line && class_now == 2'(i) &&
              class_counts[i] != olcf_pkg::COUNT_MAX) begin
            class_counts[i] <= class_counts[i] + 1'b1;
          end
        end
      end
    end
  end

  // Output register: one kept character, or four count beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt_mode  <= 1'b0;
      cnt_idx   <= '0;
    end else if (in_fire && end_of_file) begin
      out_valid <= 1'b1;
      cnt_mode  <= 1'b1;
      cnt_idx   <= '0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
      cnt_mode  <= 1'b0;
      cnt_idx   <= '0;
    end else if (out_fire) begin
      if (final_beat) begin
        out_valid <= 1'b0;
        cnt_mode  <= 1'b0;
      end else begin
        cnt_idx <= cnt_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_file) begin
      for (int i = 0; i < olcf_pkg::NUM_CLASSES; i++) begin
        cnt_snap[i] <= class_counts[i];
      end
    end
    if (in_fire && !end_of_file && emit) begin
      out_class <= class_now;
      out_char  <= c_mod;
    end
  end

  assign is_count    = cnt_mode;
  assign line_class  = cnt_mode ? cnt_idx : out_class;
  assign kept_char   = cnt_mode ? 8'd0 : out_char;
  assign line_count  = cnt_mode ? olcf_pkg::LINE_COUNT_W'(cnt_snap[cnt_idx]) : '0;
  assign last_result = final_beat;

  // An end of file is followed by the vertex count beat.
  a_eof_starts_counts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_file |=> out_valid && is_count && line_class == 2'd0)
    else $error("end of file did not start the count beats");

  // Count beats advance one class at a time.
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_count && !last_result |=>
      out_valid && is_count && line_class == $past(line_class) + 2'd1)
    else $error("count beats out of order");

  // No input is taken while count beats remain.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_count && !last_result |-> !in_ready)
    else $error("input taken during count beats");

  // A character result carries no count.
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_count |-> line_count == '0 && last_result)
    else $error("character result malformed");

endmodule

`default_nettype wire
